@@ sv/mexp_pkg.sv @@
`default_nettype none

package mexp_pkg;

    // Sequencer states of the exponentiation control
    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_GO,
        S_RED_WAIT,
        S_SQR_GO,
        S_SQR_WAIT,
        S_MUL_GO,
        S_MUL_WAIT,
        S_DONE
    } t_state;

    // Configuration register indexes
    typedef logic [0:0] t_cfg_index;

    localparam t_cfg_index REG_EXPONENT = 1'b0;
    localparam t_cfg_index REG_MODULUS  = 1'b1;

endpackage

`default_nettype wire

@@ sv/mexp_mulmod.sv @@
`default_nettype none

// Bit-serial modular multiplier: o_product = (i_a * i_b) mod i_m.
// Requires i_b < i_m; i_a may hold any value. One bit of i_a per cycle,
// MSB first. o_done pulses when r_acc holds the product; it holds until
// the next start.
module mexp_mulmod #(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_m,
    output logic         o_done,
    output logic [W-1:0] o_product
);

    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0]     r_acc;
    logic [W-1:0]     r_a;
    logic [W-1:0]     r_b;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W:0]   dbl;
    logic [W+1:0] diff1;
    logic [W-1:0] red1;
    logic [W:0]   sum;
    logic [W+1:0] diff2;
    logic [W-1:0] red2;

    // acc = 2*acc mod m, then acc = acc + (bit ? b : 0) mod m
    always_comb begin
        dbl   = {r_acc, 1'b0};
        diff1 = {1'b0, dbl} - {2'b00, i_m};
        red1  = diff1[W+1] ? dbl[W-1:0] : diff1[W-1:0];
        sum   = {1'b0, red1} + (r_a[W-1] ? {1'b0, r_b} : {(W+1){1'b0}});
        diff2 = {1'b0, sum} - {2'b00, i_m};
        red2  = diff2[W+1] ? sum[W-1:0] : diff2[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= red2;
            r_a   <= {r_a[W-2:0], 1'b0};
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

`default_nettype wire

@@ sv/modular_exponentiation.sv @@
`default_nettype none

// Modular exponentiation: o_power_result = i_base_value ^ exponent mod modulus.
// Configuration: write i_cfg_data to register i_cfg_index (0 exponent, 1 modulus)
// at any edge with i_cfg_wr_en high, only while the block is idle. Reset loads
// exponent 1 and modulus 209.
// Input channel: a transaction moves at an edge with i_valid high and o_stall low.
// o_stall stays high from acceptance until the result enters the output register.
// Output channel: o_valid/o_power_result move when i_stall is low. The output
// register frees the sequencer, so the next base is taken while a result waits.
// Square-and-multiply over OPERAND_BITS exponent bits, MSB first, on one
// bit-serial modular multiplier. Each base takes one product to reduce it, then
// OPERAND_BITS squarings and one multiply per set exponent bit; the next base
// is taken once the result has left the sequencer for the output register.
// Modulus 0 or 1 yields 0 without using the multiplier.
// If the receiver stalls while a result is held, the next result waits in the
// sequencer's final state and the input stays stalled.
// Reset (synchronous, active low) drops any transaction in flight.
module modular_exponentiation #(
    parameter int OPERAND_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [0:0]              i_cfg_index,
    input  logic [OPERAND_BITS-1:0] i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [OPERAND_BITS-1:0] i_base_value,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [OPERAND_BITS-1:0] o_power_result
);

    import mexp_pkg::*;

    localparam int W     = OPERAND_BITS;
    localparam int BIT_W = $clog2(W);

    localparam logic [W-1:0] EXP_RESET = W'(1);
    localparam logic [W-1:0] MOD_RESET = W'(209);

    t_state r_state;
    t_state n_state;

    logic [W-1:0]     r_exponent;
    logic [W-1:0]     r_modulus;
    logic [W-1:0]     r_acc;
    logic [W-1:0]     n_acc;
    logic [W-1:0]     r_base;
    logic [W-1:0]     n_base;
    logic [BIT_W-1:0] r_bit;
    logic [BIT_W-1:0] n_bit;
    logic             r_out_valid;
    logic [W-1:0]     r_out_data;

    logic         mm_start;
    logic [W-1:0] mm_a;
    logic [W-1:0] mm_b;
    logic         mm_done;
    logic [W-1:0] mm_product;
    logic         in_accept;
    logic         out_free;
    logic         out_load;
    logic         mod_trivial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= EXP_RESET;
            r_modulus  <= MOD_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_EXPONENT: r_exponent <= i_cfg_data;
                REG_MODULUS:  r_modulus  <= i_cfg_data;
                default:      r_modulus  <= r_modulus;
            endcase
        end
    end

    mexp_mulmod #(
        .W(W)
    ) u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mm_start),
        .i_a       (mm_a),
        .i_b       (mm_b),
        .i_m       (r_modulus),
        .o_done    (mm_done),
        .o_product (mm_product)
    );

    assign o_stall     = (r_state != S_IDLE);
    assign in_accept   = i_valid && !o_stall;
    assign out_free    = !r_out_valid || !i_stall;
    assign mod_trivial = (r_modulus[W-1:1] == '0);

    always_comb begin
        n_state  = r_state;
        n_acc    = r_acc;
        n_base   = r_base;
        n_bit    = r_bit;
        mm_start = 1'b0;
        mm_a     = r_acc;
        mm_b     = r_acc;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_base = i_base_value;
                    n_bit  = BIT_W'(W - 1);
                    if (mod_trivial) begin
                        n_acc   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_acc   = W'(1);
                        n_state = S_RED_GO;
                    end
                end
            end
            S_RED_GO: begin
                // reduce the base: base * 1 mod m
                mm_start = 1'b1;
                mm_a     = r_base;
                mm_b     = W'(1);
                n_state  = S_RED_WAIT;
            end
            S_RED_WAIT: begin
                if (mm_done) begin
                    n_base  = mm_product;
                    n_state = S_SQR_GO;
                end
            end
            S_SQR_GO: begin
                mm_start = 1'b1;
                n_state  = S_SQR_WAIT;
            end
            S_SQR_WAIT: begin
                if (mm_done) begin
                    n_acc = mm_product;
                    if (r_exponent[r_bit]) begin
                        n_state = S_MUL_GO;
                    end else if (r_bit == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_bit   = r_bit - 1'b1;
                        n_state = S_SQR_GO;
                    end
                end
            end
            S_MUL_GO: begin
                mm_start = 1'b1;
                mm_b     = r_base;
                n_state  = S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
                if (mm_done) begin
                    n_acc = mm_product;
                    if (r_bit == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_bit   = r_bit - 1'b1;
                        n_state = S_SQR_GO;
                    end
                end
            end
            S_DONE: begin
                // hold until the output register frees up
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_base <= n_base;
        r_bit  <= n_bit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= r_acc;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_power_result = r_out_data;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mexp_pkg::*;

    localparam int OPERAND_BITS = 16;
    localparam int LATENCY_CYCLES = 700;

    typedef logic [OPERAND_BITS-1:0] t_word;

    typedef struct {
        t_word base;
        t_word power;
    } t_power_entry;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_wr_en = 1'b0;
    t_cfg_index i_cfg_index = REG_EXPONENT;
    t_word      i_cfg_data = '0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    t_word      i_base_value = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    t_word      o_power_result;

    // Bench copy of the key registers, reset values first
    t_word cur_exponent = 16'd1;
    t_word cur_modulus = 16'd209;

    t_power_entry pending_powers[$];
    int err_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_left = 0;

    modular_exponentiation #(
        .OPERAND_BITS(OPERAND_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_base_value(i_base_value),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_power_result(o_power_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Square-and-multiply from the top exponent bit, reducing every product
    function automatic t_word expected_power(t_word base, t_word expo, t_word modn);
        logic [2*OPERAND_BITS-1:0] acc;
        logic [2*OPERAND_BITS-1:0] red_base;
        int k;
        if (modn == '0) begin
            return '0;
        end
        acc = 1 % modn;
        red_base = base % modn;
        for (k = OPERAND_BITS - 1; k >= 0; k--) begin
            acc = (acc * acc) % modn;
            if (expo[k]) begin
                acc = (acc * red_base) % modn;
            end
        end
        return acc[OPERAND_BITS-1:0];
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Receiver: random stall, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Compare each accepted result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_power_entry want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_powers.size() == 0) begin
                report_mismatch($sformatf("unexpected power_result %0d", o_power_result));
            end else begin
                want = pending_powers.pop_front();
                if (o_power_result !== want.power) begin
                    report_mismatch($sformatf(
                        "base %0d exp %0d mod %0d: power_result %0d, want %0d",
                        want.base, cur_exponent, cur_modulus, o_power_result, want.power));
                end
            end
        end
    end

    task automatic send_base(t_word base);
        t_power_entry entry;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_base_value <= base;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        entry.base = base;
        entry.power = expected_power(base, cur_exponent, cur_modulus);
        pending_powers.push_back(entry);
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (pending_powers.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Write both registers on back-to-back edges; call only while idle
    task automatic set_keys(t_word expo, t_word modn);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_EXPONENT;
        i_cfg_data <= expo;
        @(posedge i_clk);
        i_cfg_index <= REG_MODULUS;
        i_cfg_data <= modn;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_exponent = expo;
        cur_modulus = modn;
    endtask

    function automatic t_word pick_exponent();
        case ($urandom_range(7))
            0: return '0;
            1: return 16'd1;
            2: return '1;
            3: return 16'd3;
            4: return 16'd17;
            default: return t_word'($urandom_range(65535));
        endcase
    endfunction

    function automatic t_word pick_modulus();
        case ($urandom_range(19))
            0: return 16'd2;
            1: return '1;
            2: return 16'd209;
            3: return t_word'($urandom_range(1));
            4, 5: return t_word'($urandom_range(255, 2));
            default: return t_word'($urandom_range(65535, 2));
        endcase
    endfunction

    function automatic t_word pick_base(t_word modn);
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return modn - 16'd1;
            3: return modn;
            4, 5: return (modn > 1) ? t_word'($urandom_range(modn - 1)) : '0;
            default: return t_word'($urandom_range(65535));
        endcase
    endfunction

    task automatic test_reset_keys();
        send_base(16'd0);
        send_base(16'd208);
        send_base(16'd209);
        send_base('1);
        wait_drain();
    endtask

    task automatic test_key_extremes();
        // exponent zero, including zero to the zero
        set_keys('0, 16'd209);
        send_base(16'd0);
        send_base(16'd5);
        send_base('1);
        wait_drain();
        set_keys('1, '1);
        send_base(16'd65534);
        send_base('1);
        send_base(16'd12345);
        wait_drain();
        set_keys('1, 16'd2);
        send_base(16'd0);
        send_base(16'd1);
        send_base(16'd3);
        wait_drain();
        // modulus one and modulus zero both give zero
        set_keys(16'd3, 16'd1);
        send_base(16'd7);
        send_base('1);
        wait_drain();
        set_keys(16'd17, 16'd0);
        send_base(16'd9);
        send_base('0);
        wait_drain();
    endtask

    task automatic test_random_bases(int idle_snd, int idle_rcv);
        send_idle_pct = idle_snd;
        recv_idle_pct = idle_rcv;
        repeat (3) begin
            set_keys(pick_exponent(), pick_modulus());
            repeat (100) begin
                send_base(pick_base(cur_modulus));
            end
            wait_drain();
        end
    endtask

    task automatic test_output_holdoff();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_keys(16'd3, 16'd3233);
        // Hold the output long enough that the block backs up and stalls its input
        hold_req = 3000;
        repeat (6) begin
            send_base(t_word'($urandom_range(65535)));
        end
        wait_drain();
    endtask

    task automatic test_paused_sender();
        send_idle_pct = 7;
        recv_idle_pct = 74;
        set_keys(16'd2753, 16'd3233);
        repeat (4) begin
            send_base(t_word'($urandom_range(3232)));
        end
        // Pause until every result is back, then resume
        wait_drain();
        repeat (4) begin
            send_base(t_word'($urandom_range(65535)));
        end
        wait_drain();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_keys();
        test_key_extremes();
        test_output_holdoff();
        test_paused_sender();
        test_random_bases(7, 74);
        test_random_bases(74, 7);
        test_random_bases(0, 0);
        wait_drain();
        repeat (LATENCY_CYCLES) @(posedge i_clk);
        if (err_count == 0 && pending_powers.size() == 0) begin
            $display("modular_exponentiation verification clean");
        end else begin
            $display("modular_exponentiation verification failed");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("modular_exponentiation verification failed");
        $finish;
    end

endmodule

`default_nettype wire
